[hdl/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is high
`define BTS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never hold
`define BTS_ASSERT_NEVER(name, cond, msg) \
  `BTS_ASSERT(name, !(cond), msg)

`endif

[hdl/bts_pkg.sv]
// ----------------------------------------------------------------------------
// bts_pkg
// Types and constants of the batch timeline slot table.
// ----------------------------------------------------------------------------
package bts_pkg;

  localparam int DEF_MAX_SLOTS = 64;
  localparam int REQ_W         = 2;
  localparam int POS_W         = 6;
  localparam int TAG_W         = 16;
  localparam int TIME_W        = 24;
  localparam int CNT_OUT_W     = 7;

  localparam logic [REQ_W-1:0] REQ_GAP    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_AT     = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_OVF    = 2'd3
  } status_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [POS_W-1:0]  position;
    logic [TAG_W-1:0]  entry_tag;
    logic [TIME_W-1:0] release_time;
    logic [TIME_W-1:0] processing_time;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [POS_W-1:0]     placed_position;
    logic [TAG_W-1:0]     placed_tag;
    logic [TIME_W-1:0]    start_time;
    logic [TIME_W-1:0]    completion_time;
    logic [CNT_OUT_W-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] rel;
    logic [TIME_W-1:0] dur;
    logic [TIME_W-1:0] start;
  } entry_t;

endpackage

[hdl/bts_if.sv]
// ----------------------------------------------------------------------------
// bts_if
// Valid/ready channels for requests and responses of the slot table.
// ----------------------------------------------------------------------------
interface bts_req_if import bts_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bts_rsp_if import bts_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/bts_ram.sv]
// ----------------------------------------------------------------------------
// bts_ram
// Generic one-write one-read RAM, registered read, read-before-write.
// ----------------------------------------------------------------------------
module bts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/batch_timeline_slot_table_core.sv]
// ----------------------------------------------------------------------------
// batch_timeline_slot_table_core
// Ordered timeline of batches on one machine: gap insert, positional insert
// and remove, with start times rippled through the table one entry a cycle.
// ----------------------------------------------------------------------------
//  channel  dir  payload  beat when
//  req      in   req_t    req.valid && req.ready
//  rsp      out  rsp_t    rsp.valid && rsp.ready
//
//  gap insert scans for the first fitting gap, then walks the chain from p
//  twice (overflow check pass, then commit pass); positional insert does the
//  two passes only; remove shifts the later entries down one entry per cycle.
//  reset empties the table at once; no clearing pass.
//  ready is high only while idle; a waiting response does not block a beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module batch_timeline_slot_table_core import bts_pkg::*; #(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
  input logic      clk,
  input logic      rst,
  bts_req_if.sink  req,
  bts_rsp_if.source rsp
);

  localparam int IW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SCAN, S_PREV, S_PREV_WAIT, S_CHAIN,
    S_RM_READ, S_RM_WAIT, S_RM_SHIFT, S_DONE
  } state_t;

  state_t            state;
  logic [CW-1:0]     cnt;
  logic [REQ_W-1:0]  rq;
  logic [POS_W-1:0]  pos_r;
  logic [TAG_W-1:0]  tag_r;
  logic [TIME_W-1:0] rel_r;
  logic [TIME_W-1:0] dur_r;
  logic [CW-1:0]     p;
  logic [CW-1:0]     k;
  logic [CW-1:0]     bidx;
  logic              rdv;
  logic              first;
  logic              commit;
  logic [TIME_W-1:0] prev;
  rsp_t              res;
  logic              out_valid;
  rsp_t              out_data;

  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [IW-1:0]     ram_raddr;
  entry_t            ram_wdata;
  entry_t            rd;

  logic [TIME_W:0]   done_rd;
  logic [TAG_W-1:0]  src_tag;
  logic [TIME_W-1:0] src_rel;
  logic [TIME_W-1:0] src_dur;
  logic [TIME_W-1:0] ch_s;
  logic [TIME_W:0]   ch_c;
  logic [TIME_W-1:0] gap_s;
  logic              fit;
  logic [TIME_W-1:0] rm_s;
  logic [TIME_W:0]   rm_done;
  logic [CW-1:0]     k1;
  logic [CW-1:0]     k2;
  logic [CW-1:0]     pm1;
  logic [CW-1:0]     p1;

  function automatic rsp_t err_rsp(status_t s);
    rsp_t r;
    r = '0;
    r.status = s;
    return r;
  endfunction

  bts_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  assign k1  = k + CW'(1);
  assign k2  = k + CW'(2);
  assign pm1 = p - CW'(1);
  assign p1  = p + CW'(1);

  assign done_rd = {1'b0, rd.start} + {1'b0, rd.dur};

  // chain source: the new entry first, then the displaced old entries
  assign src_tag = first ? tag_r : rd.tag;
  assign src_rel = first ? rel_r : rd.rel;
  assign src_dur = first ? dur_r : rd.dur;
  assign ch_s    = (prev > src_rel) ? prev : src_rel;
  assign ch_c    = {1'b0, ch_s} + {1'b0, src_dur};

  assign gap_s = (prev > rel_r) ? prev : rel_r;
  assign fit   = ({1'b0, gap_s} + {1'b0, dur_r}) <= {1'b0, rd.start};

  assign rm_s    = (prev < rd.start) ? ((prev <= rd.rel) ? rd.rel : prev) : rd.start;
  assign rm_done = {1'b0, rm_s} + {1'b0, rd.dur};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = k[IW-1:0];
    ram_raddr = k[IW-1:0];
    ram_wdata = '{tag: src_tag, rel: src_rel, dur: src_dur, start: ch_s};
    unique case (state)
      S_PREV:    ram_raddr = pm1[IW-1:0];
      S_CHAIN:   ram_we = commit;
      S_RM_READ: ram_raddr = p[IW-1:0];
      S_RM_WAIT: ram_raddr = p1[IW-1:0];
      S_RM_SHIFT: begin
        ram_raddr = k2[IW-1:0];
        ram_we    = (k1 < cnt);
        ram_wdata = '{tag: rd.tag, rel: rd.rel, dur: rd.dur, start: rm_s};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            rq    <= req.data.req_type;
            pos_r <= req.data.position;
            tag_r <= req.data.entry_tag;
            rel_r <= req.data.release_time;
            dur_r <= req.data.processing_time;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          commit <= 1'b0;
          if (rq == REQ_GAP || rq == REQ_AT) begin
            if (cnt == CW'(MAX_SLOTS)) begin
              res   <= err_rsp(ST_FULL);
              state <= S_DONE;
            end else if (rq == REQ_GAP) begin
              res   <= '0;
              k     <= '0;
              rdv   <= 1'b0;
              prev  <= '0;
              state <= S_SCAN;
            end else begin
              res   <= '0;
              p     <= (XW'(pos_r) > XW'(cnt)) ? cnt : CW'(pos_r);
              state <= S_PREV;
            end
          end else if (rq == REQ_REMOVE && XW'(pos_r) < XW'(cnt)) begin
            res   <= '0;
            p     <= CW'(pos_r);
            state <= S_PREV;
          end else begin
            res   <= err_rsp(ST_BADPOS);
            state <= S_DONE;
          end
        end
        S_SCAN: begin
          if (rdv && fit) begin
            p     <= bidx;
            state <= S_PREV;
          end else if (!rdv && k >= cnt) begin
            p     <= cnt;
            state <= S_PREV;
          end else begin
            if (rdv) begin
              prev <= done_rd[TIME_W-1:0];
            end
            rdv  <= (k < cnt);
            bidx <= k;
            if (k < cnt) begin
              k <= k1;
            end
          end
        end
        S_PREV: begin
          k     <= p;
          first <= 1'b1;
          if (p == '0) begin
            prev  <= '0;
            state <= (rq == REQ_REMOVE) ? S_RM_READ : S_CHAIN;
          end else begin
            state <= S_PREV_WAIT;
          end
        end
        S_PREV_WAIT: begin
          prev  <= done_rd[TIME_W-1:0];
          state <= (rq == REQ_REMOVE) ? S_RM_READ : S_CHAIN;
        end
        S_CHAIN: begin
          if (ch_c[TIME_W]) begin
            res   <= err_rsp(ST_OVF);
            state <= S_DONE;
          end else begin
            prev  <= ch_c[TIME_W-1:0];
            first <= 1'b0;
            if (first) begin
              res.start_time      <= ch_s;
              res.completion_time <= ch_c[TIME_W-1:0];
            end
            if (k == cnt) begin
              if (!commit) begin
                commit <= 1'b1;
                state  <= S_PREV;
              end else begin
                cnt                 <= cnt + CW'(1);
                res.status          <= ST_OK;
                res.placed_position <= POS_W'(p);
                res.placed_tag      <= tag_r;
                state               <= S_DONE;
              end
            end else begin
              k <= k1;
            end
          end
        end
        S_RM_READ: begin
          state <= S_RM_WAIT;
        end
        S_RM_WAIT: begin
          res.status          <= ST_OK;
          res.placed_position <= POS_W'(p);
          res.placed_tag      <= rd.tag;
          res.start_time      <= rd.start;
          res.completion_time <= done_rd[TIME_W-1:0];
          k                   <= p;
          state               <= S_RM_SHIFT;
        end
        S_RM_SHIFT: begin
          if (k1 < cnt) begin
            prev <= rm_done[TIME_W-1:0];
            k    <= k1;
          end else begin
            cnt   <= cnt - CW'(1);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_data  <= '{status: res.status, placed_position: res.placed_position,
                           placed_tag: res.placed_tag, start_time: res.start_time,
                           completion_time: res.completion_time,
                           entry_count: CNT_OUT_W'(cnt)};
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BTS_ASSERT(a_cnt_bound, cnt <= CW'(MAX_SLOTS), "entry count above table size")
  `BTS_ASSERT(a_we_phase, ram_we |-> ((state == S_CHAIN && commit) || state == S_RM_SHIFT), "table write outside commit or shift")
  `BTS_ASSERT(a_cnt_change, (!$stable(cnt) && !$past(rst)) |-> ($past(state) == S_CHAIN || $past(state) == S_RM_SHIFT), "entry count changed outside insert or remove")
  `BTS_ASSERT_NEVER(a_commit_ovf, state == S_CHAIN && commit && ch_c[TIME_W], "overflow seen during commit pass")

endmodule

[bench/bts_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_if (bench side)
// The request and response channels are compiled from the rtl folder; the
// testbench instantiates those same interfaces.
// ----------------------------------------------------------------------------

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives gap inserts, positional inserts, removes and bad types into the
// slot table, keeps a shadow timeline to predict every response and checks
// each response field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench import bts_pkg::*; ();

  localparam int SLOTS = DEF_MAX_SLOTS;
  localparam logic [REQ_W-1:0] REQ_BAD = 2'd3;
  localparam logic [24:0] TMAX = 25'hFFFFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bts_req_if req ();
  bts_rsp_if rsp ();

  batch_timeline_slot_table_core #(.MAX_SLOTS(SLOTS)) dut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp)
  );

  always #5 clk = ~clk;

  entry_t timeline[SLOTS];
  int     n_entries = 0;
  rsp_t   pending_rsp[$];
  int     errors = 0;
  bit     calm = 1'b0;

  function automatic logic [24:0] done_of(int i);
    return {1'b0, timeline[i].start} + {1'b0, timeline[i].dur};
  endfunction

  function automatic int gap_slot(logic [23:0] rel, logic [23:0] dur);
    longint avail;
    longint cur;
    longint s;
    avail = 0;
    for (int b = 0; b < n_entries; b++) begin
      cur = longint'(timeline[b].start);
      if (b > 0) avail = longint'(done_of(b - 1));
      if (cur - avail >= dur) begin
        s = (avail > rel) ? avail : rel;
        if (s + dur <= cur) return b;
      end
    end
    return n_entries;
  endfunction

  function automatic rsp_t predict_timeline(req_t r);
    rsp_t o;
    int p;
    logic [24:0] prev, s, c;
    logic [23:0] rr, dd;
    logic [23:0] starts[SLOTS+1];
    bit ovf;
    o = '0;
    o.status = ST_OK;
    if (r.req_type == REQ_GAP || r.req_type == REQ_AT) begin
      if (n_entries >= SLOTS) begin
        o.status = ST_FULL;
      end else begin
        if (r.req_type == REQ_GAP) p = gap_slot(r.release_time, r.processing_time);
        else p = (r.position > n_entries) ? n_entries : int'(r.position);
        prev = (p == 0) ? 25'd0 : done_of(p - 1);
        ovf = 1'b0;
        for (int k = p; k <= n_entries; k++) begin
          rr = (k == p) ? r.release_time : timeline[k-1].rel;
          dd = (k == p) ? r.processing_time : timeline[k-1].dur;
          s = (prev > {1'b0, rr}) ? prev : {1'b0, rr};
          c = s + dd;
          if (c > TMAX) ovf = 1'b1;
          starts[k] = s[23:0];
          prev = c;
        end
        if (ovf) begin
          o.status = ST_OVF;
        end else begin
          for (int k = n_entries; k > p; k--) timeline[k] = timeline[k-1];
          timeline[p].tag = r.entry_tag;
          timeline[p].rel = r.release_time;
          timeline[p].dur = r.processing_time;
          for (int k = p; k <= n_entries; k++) timeline[k].start = starts[k];
          n_entries++;
          o.placed_position = p[5:0];
          o.placed_tag = r.entry_tag;
          o.start_time = timeline[p].start;
          o.completion_time = 24'(done_of(p));
        end
      end
    end else if (r.req_type == REQ_REMOVE) begin
      if (r.position >= n_entries) begin
        o.status = ST_BADPOS;
      end else begin
        p = int'(r.position);
        o.placed_position = r.position;
        o.placed_tag = timeline[p].tag;
        o.start_time = timeline[p].start;
        o.completion_time = 24'(done_of(p));
        for (int b = p; b + 1 < n_entries; b++) begin
          timeline[b] = timeline[b+1];
          prev = (b == 0) ? 25'd0 : done_of(b - 1);
          if (prev < {1'b0, timeline[b].start})
            timeline[b].start = (prev <= {1'b0, timeline[b].rel}) ?
                                timeline[b].rel : prev[23:0];
        end
        n_entries--;
      end
    end else begin
      o.status = ST_BADPOS;
    end
    o.entry_count = n_entries[6:0];
    return o;
  endfunction

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 17);
  endfunction

  task automatic send_beat(logic [1:0] t, logic [5:0] pos, logic [15:0] tag,
                           logic [23:0] rel, logic [23:0] dur);
    req_t r;
    r = {t, pos, tag, rel, dur};
    while (idle_now()) @(posedge clk);
    req.valid <= 1'b1;
    req.data <= r;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pending_rsp.push_back(predict_timeline(r));
    req.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_pending();
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // response side: random stall, then check
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_rsp.size() == 0) begin
          $error("unexpected response beat");
          errors++;
        end else begin
          rsp_t e;
          e = pending_rsp.pop_front();
          if (rsp.data.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, rsp.data.status); errors++;
          end
          if (rsp.data.placed_position !== e.placed_position) begin
            $error("placed_position exp %0d got %0d", e.placed_position,
                   rsp.data.placed_position); errors++;
          end
          if (rsp.data.placed_tag !== e.placed_tag) begin
            $error("placed_tag exp %0h got %0h", e.placed_tag, rsp.data.placed_tag);
            errors++;
          end
          if (rsp.data.start_time !== e.start_time) begin
            $error("start_time exp %0d got %0d", e.start_time, rsp.data.start_time);
            errors++;
          end
          if (rsp.data.completion_time !== e.completion_time) begin
            $error("completion_time exp %0d got %0d", e.completion_time,
                   rsp.data.completion_time); errors++;
          end
          if (rsp.data.entry_count !== e.entry_count) begin
            $error("entry_count exp %0d got %0d", e.entry_count,
                   rsp.data.entry_count); errors++;
          end
        end
      end
      rsp.ready <= !idle_now();
    end
  end

  task automatic test_directed();
    send_beat(REQ_REMOVE, 6'd0, 16'h0, 24'd0, 24'd0);
    send_beat(REQ_BAD, 6'd63, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_beat(REQ_GAP, 6'd0, 16'hFFFF, 24'd100, 24'd10);
    send_beat(REQ_AT, 6'd0, 16'h0001, 24'd0, 24'd5);
    send_beat(REQ_GAP, 6'd0, 16'h0002, 24'd0, 24'd3);
    send_beat(REQ_AT, 6'd63, 16'h0003, 24'hFFFFF0, 24'hF);
    send_beat(REQ_AT, 6'd63, 16'h0004, 24'd0, 24'd1);
    send_beat(REQ_AT, 6'd1, 16'h0005, 24'hFFFFFF, 24'hFFFFFF);
    send_beat(REQ_GAP, 6'd0, 16'h0006, 24'hFFFFFF, 24'd1);
    send_beat(REQ_REMOVE, 6'd1, 16'h0, 24'd0, 24'd0);
    send_beat(REQ_REMOVE, 6'd63, 16'h0, 24'd0, 24'd0);
    send_beat(REQ_REMOVE, 6'd0, 16'h0, 24'd0, 24'd0);
    send_beat(REQ_GAP, 6'd0, 16'h0007, 24'd0, 24'd0);
    send_beat(REQ_AT, 6'd2, 16'hA5A5, 24'h555555, 24'hAAAAAA);
    drain_pending();
  endtask

  task automatic test_full_table();
    while (n_entries < SLOTS)
      send_beat(REQ_AT, 6'($urandom_range(63)), 16'($urandom),
                24'($urandom_range(5000)), 24'($urandom_range(40)));
    send_beat(REQ_GAP, 6'd0, 16'hBEEF, 24'd0, 24'd0);
    send_beat(REQ_AT, 6'd63, 16'hBEEF, 24'd0, 24'd0);
    send_beat(REQ_REMOVE, 6'd63, 16'h0, 24'd0, 24'd0);
    drain_pending();
    while (n_entries > 0) send_beat(REQ_REMOVE, 6'($urandom_range(n_entries - 1)),
                                    16'h0, 24'd0, 24'd0);
  endtask

  task automatic test_random(int count);
    logic [1:0] t;
    logic [23:0] rel, dur;
    int k;
    for (int i = 0; i < count; i++) begin
      calm = (i >= count / 3) && (i < count / 3 + 150);
      k = $urandom_range(99);
      if (k < 3) t = REQ_BAD;
      else if (n_entries > 40) t = (k < 55) ? REQ_REMOVE : ((k < 78) ? REQ_GAP : REQ_AT);
      else t = (k < 30) ? REQ_REMOVE : ((k < 65) ? REQ_GAP : REQ_AT);
      k = $urandom_range(99);
      if (k < 5) begin
        rel = 24'($urandom); dur = 24'($urandom);
      end else if (k < 10) begin
        rel = 24'hFFFFFF - 24'($urandom_range(2000)); dur = 24'($urandom_range(3000));
      end else begin
        rel = 24'($urandom_range(20000)); dur = 24'($urandom_range(500));
      end
      send_beat(t, (n_entries > 0 && $urandom_range(3) != 0) ?
                6'($urandom_range(n_entries)) : 6'($urandom), 16'($urandom), rel, dur);
      if (i == count / 2) drain_pending();
    end
    calm = 1'b0;
  endtask

  initial begin
    req.valid = 1'b0;
    req.data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_table();
    test_random(1000);
    drain_pending();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
